FILE: src/flva_pkg.sv
// Shared types, widths and codes for the FEM load vector accumulator.
// Used by flva_mac and fem_load_vector_accumulator_top; depends on nothing.
package flva_pkg;

    localparam int FUNC_W         = 2;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 2;
    localparam int DATA_W         = 32;
    localparam int ACC_W          = 48;
    localparam int FRAC_W         = 24;
    localparam int MAX_COMPONENTS = 3;
    localparam int NUM_DOFS_DEF   = 1024;

    // rounded Q.24 product of two Q8.24 values: at most 2^38 in magnitude
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int DOT_W  = TERM_W + 1;
    localparam int MAG_W  = TERM_W;
    localparam int WIDE_W = 2 * MAG_W;

    // stream widths
    localparam int IN_FIELDS_W  = IDX_W + 9 * DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ACC_W;
    localparam int OUT_TUSER_W  = 3;

    localparam int FLAG_AREA   = 0;
    localparam int FLAG_WEIGHT = 1;
    localparam int FLAG_SAT    = 2;

    localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef logic signed [DATA_W-1:0] q824_t;

    typedef struct packed {
        logic                             start;
        logic [CNT_W-1:0]                 count;
        q824_t [MAX_COMPONENTS-1:0]       shape;
        q824_t [MAX_COMPONENTS-1:0]       src;
        q824_t                            jac;
        q824_t                            weight;
    } flva_mac_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] contrib;
        logic                    sat;
    } flva_mac_rsp_t;

    function automatic logic [DATA_W-1:0] mag32(input q824_t v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
        return m;
    endfunction

endpackage

FILE: src/flva_mac.sv
// Contribution unit: dot product, jacobian times weight and the wide product,
// all on one shared 32x32 multiplier. Depends on flva_pkg.
module flva_mac
    import flva_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  flva_mac_req_t req,
    output flva_mac_rsp_t rsp
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_PROD   = 3'd1;
    localparam logic [2:0] PH_DRAIN  = 3'd2;
    localparam logic [2:0] PH_WIDE   = 3'd3;
    localparam logic [2:0] PH_WDRAIN = 3'd4;
    localparam logic [2:0] PH_ROUND  = 3'd5;
    localparam logic [2:0] PH_CLAMP  = 3'd6;

    localparam logic [2:0] TAG_DOT = 3'd0;
    localparam logic [2:0] TAG_JW  = 3'd1;
    localparam logic [2:0] TAG_LL  = 3'd2;
    localparam logic [2:0] TAG_MID = 3'd3;
    localparam logic [2:0] TAG_HH  = 3'd4;

    localparam int Q_W = WIDE_W - FRAC_W;
    localparam logic [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (FRAC_W - 1);
    localparam logic [WIDE_W-1:0] WIDE_HALF = WIDE_W'(1) << (FRAC_W - 1);
    localparam logic [Q_W-1:0]    POS_LIM   = {{(Q_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic [Q_W-1:0]    NEG_LIM   = POS_LIM + Q_W'(1);
    localparam logic [1:0]        LAST_PART = 2'd3;

    logic [2:0]              phase_reg;
    logic [1:0]              iss_reg;
    logic [CNT_W-1:0]        n_eff;
    logic                    empty;

    logic                    issue;
    logic [2:0]              iss_tag;
    logic [DATA_W-1:0]       iss_opa;
    logic [DATA_W-1:0]       iss_opb;
    logic                    iss_neg;

    logic                    a_valid_reg;
    logic [2:0]              a_tag_reg;
    logic [DATA_W-1:0]       a_opa_reg;
    logic [DATA_W-1:0]       a_opb_reg;
    logic                    a_neg_reg;

    logic                    b_valid_reg;
    logic [2:0]              b_tag_reg;
    logic [PROD_W-1:0]       b_prod_reg;
    logic                    b_neg_reg;

    logic [PROD_W-1:0]       prod_rnd;
    logic [TERM_W-1:0]       term_mag;
    logic signed [TERM_W-1:0] term;
    logic [WIDE_W-1:0]       wide_add;
    logic [WIDE_W-1:0]       wide_rnd;

    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [TERM_W-1:0] jw_reg;
    logic [MAG_W-1:0]         ma_reg;
    logic [MAG_W-1:0]         mb_reg;
    logic                     wneg_reg;
    logic [WIDE_W-1:0]        wide_reg;
    logic [Q_W-1:0]           q_reg;

    logic [Q_W-1:0]           lim;
    logic                     q_over;
    logic [ACC_W-1:0]         r48;

    logic                     done_reg;
    logic signed [ACC_W-1:0]  contrib_reg;
    logic                     sat_reg;

    logic [TERM_W-1:0]        jw_mag;
    logic [DOT_W-1:0]         dot_mag;

    always_comb
    begin
        if (req.count == '0)
            n_eff = CNT_W'(1);
        else if (req.count > CNT_W'(MAX_COMPONENTS))
            n_eff = CNT_W'(MAX_COMPONENTS);
        else
            n_eff = req.count;
    end

    assign empty = !a_valid_reg && !b_valid_reg;

    // operand select for the product issued this cycle
    always_comb
    begin
        issue   = 1'b0;
        iss_tag = TAG_DOT;
        iss_opa = '0;
        iss_opb = '0;
        iss_neg = 1'b0;
        case (phase_reg)
            PH_PROD:
            begin
                issue = 1'b1;
                if (CNT_W'(iss_reg) < n_eff)
                begin
                    iss_tag = TAG_DOT;
                    iss_opa = mag32(req.shape[iss_reg]);
                    iss_opb = mag32(req.src[iss_reg]);
                    iss_neg = req.shape[iss_reg][DATA_W-1] ^ req.src[iss_reg][DATA_W-1];
                end
                else
                begin
                    iss_tag = TAG_JW;
                    iss_opa = mag32(req.jac);
                    iss_opb = mag32(req.weight);
                    iss_neg = req.jac[DATA_W-1] ^ req.weight[DATA_W-1];
                end
            end
            PH_WIDE:
            begin
                issue = 1'b1;
                case (iss_reg)
                    2'd0:
                    begin
                        iss_tag = TAG_LL;
                        iss_opa = ma_reg[DATA_W-1:0];
                        iss_opb = mb_reg[DATA_W-1:0];
                    end
                    2'd1:
                    begin
                        iss_tag = TAG_MID;
                        iss_opa = ma_reg[DATA_W-1:0];
                        iss_opb = DATA_W'(mb_reg[MAG_W-1:DATA_W]);
                    end
                    2'd2:
                    begin
                        iss_tag = TAG_MID;
                        iss_opa = DATA_W'(ma_reg[MAG_W-1:DATA_W]);
                        iss_opb = mb_reg[DATA_W-1:0];
                    end
                    default:
                    begin
                        iss_tag = TAG_HH;
                        iss_opa = DATA_W'(ma_reg[MAG_W-1:DATA_W]);
                        iss_opb = DATA_W'(mb_reg[MAG_W-1:DATA_W]);
                    end
                endcase
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // round magnitude to nearest, ties away from zero, then restore the sign
    always_comb
    begin
        prod_rnd = b_prod_reg + PROD_HALF;
        term_mag = prod_rnd[PROD_W-1:FRAC_W];
        term     = b_neg_reg ? -signed'(term_mag) : signed'(term_mag);
        case (b_tag_reg)
            TAG_LL:  wide_add = WIDE_W'(b_prod_reg);
            TAG_MID: wide_add = WIDE_W'(b_prod_reg) << DATA_W;
            default: wide_add = WIDE_W'(b_prod_reg) << (2 * DATA_W);
        endcase
        wide_rnd = wide_reg + WIDE_HALF;
        jw_mag   = jw_reg[TERM_W-1] ? TERM_W'(-jw_reg) : TERM_W'(jw_reg);
        dot_mag  = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
        lim      = wneg_reg ? NEG_LIM : POS_LIM;
        q_over   = q_reg > lim;
        r48      = q_over ? lim[ACC_W-1:0] : q_reg[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            iss_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
            done_reg    <= (phase_reg == PH_CLAMP);
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        phase_reg <= PH_PROD;
                        iss_reg   <= '0;
                    end
                end
                PH_PROD:
                begin
                    if (CNT_W'(iss_reg) < n_eff)
                        iss_reg <= iss_reg + 2'd1;
                    else
                        phase_reg <= PH_DRAIN;
                end
                PH_DRAIN:
                begin
                    if (empty)
                    begin
                        phase_reg <= PH_WIDE;
                        iss_reg   <= '0;
                    end
                end
                PH_WIDE:
                begin
                    if (iss_reg == LAST_PART)
                        phase_reg <= PH_WDRAIN;
                    else
                        iss_reg <= iss_reg + 2'd1;
                end
                PH_WDRAIN:
                begin
                    if (empty)
                        phase_reg <= PH_ROUND;
                end
                PH_ROUND:
                begin
                    phase_reg <= PH_CLAMP;
                end
                PH_CLAMP:
                begin
                    phase_reg <= PH_IDLE;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            a_tag_reg <= iss_tag;
            a_opa_reg <= iss_opa;
            a_opb_reg <= iss_opb;
            a_neg_reg <= iss_neg;
        end
        b_prod_reg <= a_opa_reg * a_opb_reg;
        b_tag_reg  <= a_tag_reg;
        b_neg_reg  <= a_neg_reg;

        if (phase_reg == PH_IDLE && req.start)
            dot_reg <= '0;
        else if (b_valid_reg && b_tag_reg == TAG_DOT)
            dot_reg <= dot_reg + DOT_W'(term);

        if (b_valid_reg && b_tag_reg == TAG_JW)
            jw_reg <= term;

        if (phase_reg == PH_DRAIN && empty)
        begin
            ma_reg   <= jw_mag;
            mb_reg   <= dot_mag[MAG_W-1:0];
            wneg_reg <= jw_reg[TERM_W-1] ^ dot_reg[DOT_W-1];
            wide_reg <= '0;
        end
        else if (b_valid_reg && b_tag_reg != TAG_DOT && b_tag_reg != TAG_JW)
        begin
            wide_reg <= wide_reg + wide_add;
        end

        if (phase_reg == PH_ROUND)
            q_reg <= wide_rnd[WIDE_W-1:FRAC_W];

        if (phase_reg == PH_CLAMP)
        begin
            contrib_reg <= wneg_reg ? -signed'(r48) : signed'(r48);
            sat_reg     <= q_over;
        end
    end

    always_comb
    begin
        rsp.done    = done_reg;
        rsp.contrib = contrib_reg;
        rsp.sat     = sat_reg;
    end

endmodule

FILE: src/fem_load_vector_accumulator_top.sv
// Top level of the FEM load vector accumulator: stream ports, accumulator
// memory and item sequencer. Depends on flva_pkg and flva_mac.
//
// After reset the block sweeps the accumulator memory to zero, one entry per
// cycle; s_tready stays low during the sweep while configuration writes are
// still taken. Items are handled one at a time. Read, read-and-clear,
// out-of-range and skipped accumulate items pass accept, memory read and
// result. For an accumulate item (num_components of zero counts as one)
// the shared 32x32 multiplier in flva_mac forms the component products,
// jacobian times weight and four partial products of the wide product one
// after another, and the rounding and clamping follow. The result waits in
// an output register, so a new item is accepted while the previous result
// is still pending on the master side. Each entry is read, updated and
// written back before the next item is accepted.
module fem_load_vector_accumulator_top
    import flva_pkg::*;
#(
    parameter int NUM_DOFS = NUM_DOFS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: cfg_data = num_components
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CNT_W-1:0]       cfg_data,
    // s_tdata, low bit up: dof_index, shape_c0, shape_c1, shape_c2, src_c0,
    // src_c1, src_c2, jacobian_det, quad_weight, element_area, zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: func
    input  logic [FUNC_W-1:0]      s_tuser,
    // m_tdata: entry_value
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser, low bit up: zero_area_skip, zero_weight_skip, saturated
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam int ADDR_W = (NUM_DOFS > 1) ? $clog2(NUM_DOFS) : 1;
    localparam int EXT_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_DOFS - 1);

    localparam int OFF_SHAPE  = IDX_W;
    localparam int OFF_SRC    = OFF_SHAPE + MAX_COMPONENTS * DATA_W;
    localparam int OFF_JAC    = OFF_SRC + MAX_COMPONENTS * DATA_W;
    localparam int OFF_WEIGHT = OFF_JAC + DATA_W;
    localparam int OFF_AREA   = OFF_WEIGHT + DATA_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_SUM   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic [ADDR_W-1:0]        clr_addr_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [CNT_W-1:0]         num_components_reg;

    logic [FUNC_W-1:0]        func_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        addr_reg;
    q824_t [MAX_COMPONENTS-1:0] shape_reg;
    q824_t [MAX_COMPONENTS-1:0] src_reg;
    q824_t                    jac_reg;
    q824_t                    weight_reg;
    q824_t                    area_reg;

    logic [ACC_W-1:0]         acc_mem [NUM_DOFS];
    logic [ACC_W-1:0]         rd_data_reg;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ACC_W-1:0]         wr_data;

    logic                     accept;
    logic                     out_free;
    logic [EXT_W-1:0]         in_idx_ext;
    logic                     in_range;
    logic                     is_acc;
    logic                     area_pos;
    logic                     weight_pos;
    logic                     go;

    logic signed [ACC_W-1:0]  entry_reg;
    logic signed [ACC_W:0]    sum_full;
    logic signed [ACC_W-1:0]  sum_val;
    logic                     sum_sat;

    logic [ACC_W-1:0]         res_value_reg;
    logic                     res_area_reg;
    logic                     res_weight_reg;
    logic                     res_sat_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;
    logic [OUT_TUSER_W-1:0]   m_tuser_reg;

    flva_mac_req_t            mac_req;
    flva_mac_rsp_t            mac_rsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign in_idx_ext = EXT_W'(s_tdata[IDX_W-1:0]);

    always_comb
    begin
        in_range   = 32'(idx_reg) < 32'(NUM_DOFS);
        is_acc     = (func_reg == FUNC_ACC);
        area_pos   = area_reg > q824_t'(0);
        weight_pos = weight_reg > q824_t'(0);
        go         = in_range && is_acc && area_pos && weight_pos;

        sum_full = {entry_reg[ACC_W-1], entry_reg}
                 + {mac_rsp.contrib[ACC_W-1], mac_rsp.contrib};
        sum_sat  = sum_full[ACC_W] != sum_full[ACC_W-1];
        if (!sum_sat)
            sum_val = sum_full[ACC_W-1:0];
        else if (sum_full[ACC_W])
            sum_val = ACC_MIN;
        else
            sum_val = ACC_MAX;
    end

    always_comb
    begin
        mac_req.start  = (state_reg == ST_READ) && go;
        mac_req.count  = num_components_reg;
        mac_req.shape  = shape_reg;
        mac_req.src    = src_reg;
        mac_req.jac    = jac_reg;
        mac_req.weight = weight_reg;
    end

    flva_mac u_mac (
        .clk (clk),
        .rst_n (rst_n),
        .req (mac_req),
        .rsp (mac_rsp)
    );

    // memory ports
    always_comb
    begin
        rd_en   = accept;
        rd_addr = in_idx_ext[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
            end
            ST_READ:
            begin
                wr_en = in_range && (func_reg == FUNC_CLEAR);
            end
            ST_SUM:
            begin
                wr_en   = 1'b1;
                wr_data = sum_val;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            acc_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= acc_mem[rd_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = go ? ST_MAC : ST_EMIT;
            end
            ST_MAC:
            begin
                if (mac_rsp.done)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clr_addr_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
            num_components_reg <= CNT_W'(1);
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
                num_components_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= s_tuser;
            idx_reg    <= s_tdata[IDX_W-1:0];
            addr_reg   <= in_idx_ext[ADDR_W-1:0];
            for (int k = 0; k < MAX_COMPONENTS; k++)
            begin
                shape_reg[k] <= s_tdata[OFF_SHAPE + k * DATA_W +: DATA_W];
                src_reg[k]   <= s_tdata[OFF_SRC + k * DATA_W +: DATA_W];
            end
            jac_reg    <= s_tdata[OFF_JAC +: DATA_W];
            weight_reg <= s_tdata[OFF_WEIGHT +: DATA_W];
            area_reg   <= s_tdata[OFF_AREA +: DATA_W];
        end

        if (state_reg == ST_READ)
        begin
            entry_reg      <= rd_data_reg;
            res_value_reg  <= in_range ? rd_data_reg : '0;
            res_area_reg   <= in_range && is_acc && !area_pos;
            res_weight_reg <= in_range && is_acc && area_pos && !weight_pos;
            res_sat_reg    <= 1'b0;
        end
        else if (state_reg == ST_SUM)
        begin
            res_value_reg <= sum_val;
            res_sat_reg   <= mac_rsp.sat || sum_sat;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            m_tdata_reg              <= res_value_reg;
            m_tuser_reg[FLAG_AREA]   <= res_area_reg;
            m_tuser_reg[FLAG_WEIGHT] <= res_weight_reg;
            m_tuser_reg[FLAG_SAT]    <= res_sat_reg;
        end
    end

    // the contribution unit only finishes an operation the sequencer waits on
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_rsp.done |-> state_reg == ST_MAC)
        else $error("contribution unit finished outside of an accumulate");

    // no memory write while waiting for an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("accumulator write while idle");

    // every accepted transfer starts with a memory read
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_READ)
        else $error("accepted transfer not followed by entry read");

    // a skipped contribution never reports saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[FLAG_SAT] && (m_tuser[FLAG_AREA] || m_tuser[FLAG_WEIGHT])))
        else $error("saturation flagged on a skipped item");

endmodule

FILE: bench/tb_fem_load_vector_accumulator_top.sv
// Self-checking bench for fem_load_vector_accumulator_top: directed and random
// accumulate/read/clear transfers checked against an in-bench load vector model.
// Depends on flva_pkg and the RTL under src/.
module tb_fem_load_vector_accumulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import flva_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int STUCK_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_CYCLES   = 200;

    localparam logic [FUNC_W-1:0] FUNC_READ_ALT = 2'd3;

    localparam q824_t Q_ONE = 32'sh0100_0000;
    localparam q824_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q824_t Q_MIN = 32'sh8000_0000;
    localparam q824_t Q_HALF_LSB = 32'sh0080_0000;

    localparam longint ENTRY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ENTRY_MIN = -64'sh0000_8000_0000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic [IDX_W-1:0]           idx;
        q824_t [MAX_COMPONENTS-1:0] shape;
        q824_t [MAX_COMPONENTS-1:0] src;
        q824_t                      jac;
        q824_t                      weight;
        q824_t                      area;
    } load_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             area_skip;
        logic             weight_skip;
        logic             sat;
    } entry_result_t;

    class load_vector_scoreboard;
        longint        entries[NUM_DOFS_DEF];
        logic [CNT_W-1:0] comp_count;
        entry_result_t results_due[$];
        int errors;
        int n_acc, n_skip, n_sat, n_read, n_clear;

        function new();
            foreach (entries[i])
                entries[i] = 0;
            comp_count = CNT_W'(1);
        endfunction

        function void set_components(logic [CNT_W-1:0] n);
            comp_count = n;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        static function longint sext(logic [DATA_W-1:0] v);
            longint x;
            x = $signed(v);
            return x;
        endfunction

        // Q8.24 x Q8.24 -> Q.24, round half away from zero
        static function longint round_product(longint a, longint b);
            longint p;
            longint unsigned m;
            p = a * b;
            m = (p < 0) ? -p : p;
            m = (m + 64'd8388608) >> 24;
            return (p < 0) ? -longint'(m) : longint'(m);
        endfunction

        // wide Q.24 product, rounded, clamped to the 48-bit entry range
        static function longint scale_contrib(longint jw, longint dot, inout bit clamped);
            longint unsigned ma, mb, lim;
            logic [127:0] w;
            bit neg;
            ma = (jw < 0) ? -jw : jw;
            mb = (dot < 0) ? -dot : dot;
            neg = (jw < 0) != (dot < 0);
            lim = neg ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
            w = ({64'd0, ma} * {64'd0, mb} + 128'd8388608) >> 24;
            if (w > {64'd0, lim})
            begin
                clamped = 1'b1;
                w = {64'd0, lim};
            end
            return neg ? -longint'(w[63:0]) : longint'(w[63:0]);
        endfunction

        function void note_input(load_item_t it);
            entry_result_t r;
            longint value, dot, jw, contrib, sum;
            int n;
            bit clamped;
            r = '0;
            clamped = 1'b0;
            value = entries[it.idx];
            if (it.func == FUNC_ACC)
            begin
                n_acc++;
                if (sext(it.area) <= 0)
                begin
                    r.area_skip = 1'b1;
                    n_skip++;
                end
                else if (sext(it.weight) <= 0)
                begin
                    r.weight_skip = 1'b1;
                    n_skip++;
                end
                else
                begin
                    n = (comp_count == 0) ? 1 : int'(comp_count);
                    dot = 0;
                    for (int k = 0; k < n; k++)
                        dot += round_product(sext(it.shape[k]), sext(it.src[k]));
                    jw = round_product(sext(it.jac), sext(it.weight));
                    contrib = scale_contrib(jw, dot, clamped);
                    sum = value + contrib;
                    if (sum > ENTRY_MAX)
                    begin
                        sum = ENTRY_MAX;
                        clamped = 1'b1;
                    end
                    else if (sum < ENTRY_MIN)
                    begin
                        sum = ENTRY_MIN;
                        clamped = 1'b1;
                    end
                    entries[it.idx] = sum;
                    value = sum;
                    if (clamped)
                        n_sat++;
                end
            end
            else if (it.func == FUNC_CLEAR)
            begin
                entries[it.idx] = 0;
                n_clear++;
            end
            else
                n_read++;
            r.value = value[ACC_W-1:0];
            r.sat = clamped;
            results_due.push_back(r);
        endfunction

        function void compare(string what, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [ACC_W-1:0] value, logic [OUT_TUSER_W-1:0] flags);
            entry_result_t want;
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing outstanding: expected none, actual %0h/%b",
                         $time, value, flags);
                return;
            end
            want = results_due.pop_front();
            compare("entry_value", want.value, value);
            compare("zero_area_skip", ACC_W'(want.area_skip), ACC_W'(flags[FLAG_AREA]));
            compare("zero_weight_skip", ACC_W'(want.weight_skip), ACC_W'(flags[FLAG_WEIGHT]));
            compare("saturated", ACC_W'(want.sat), ACC_W'(flags[FLAG_SAT]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    load_vector_scoreboard board;
    bit allow_stalls = 1'b1;
    bit hold_request = 1'b0;
    int stuck_cycles = 0;

    fem_load_vector_accumulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_fem_load_vector_accumulator_top: done, errors");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (allow_stalls && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic offer_item(input load_item_t it);
        int gap;
        gap = (allow_stalls && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({it.area, it.weight, it.jac, it.src[2], it.src[1], it.src[0],
                                 it.shape[2], it.shape[1], it.shape[0], it.idx});
        s_tuser  <= it.func;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_input(it);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_components(input logic [CNT_W-1:0] n);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_components(n);
    endtask

    function automatic load_item_t make_acc(logic [IDX_W-1:0] idx, q824_t s, q824_t r,
                                            q824_t j, q824_t w, q824_t a);
        load_item_t it;
        it.func   = FUNC_ACC;
        it.idx    = idx;
        it.shape  = {s, s, s};
        it.src    = {r, r, r};
        it.jac    = j;
        it.weight = w;
        it.area   = a;
        return it;
    endfunction

    function automatic load_item_t make_read(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx);
        load_item_t it;
        it = make_acc(idx, q824_t'($urandom), q824_t'($urandom), q824_t'($urandom),
                      q824_t'($urandom), q824_t'($urandom));
        it.func = func;
        return it;
    endfunction

    // mostly physically sized values, now and then full range
    function automatic q824_t rand_q824();
        if ($urandom_range(0, 7) == 0)
            return q824_t'($urandom);
        return q824_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    function automatic q824_t rand_positive();
        if ($urandom_range(0, 7) == 0)
            return q824_t'($urandom_range(1, 32'h7FFF_FFFF));
        return q824_t'($urandom_range(1, 32'h0400_0000));
    endfunction

    function automatic q824_t rand_nonpositive();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return q824_t'($urandom | 32'h8000_0000);
    endfunction

    function automatic load_item_t make_random_item();
        load_item_t it;
        logic [IDX_W-1:0] idx;
        int pick;
        // a few hot entries so sums build up and saturate
        idx = ($urandom_range(0, 2) != 0) ? IDX_W'($urandom_range(0, 7))
                                          : IDX_W'($urandom_range(0, NUM_DOFS_DEF - 1));
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            it = make_acc(idx, '0, '0, rand_q824(), rand_positive(), rand_positive());
            for (int k = 0; k < MAX_COMPONENTS; k++)
            begin
                it.shape[k] = rand_q824();
                it.src[k]   = rand_q824();
            end
            if ($urandom_range(0, 24) == 0)
                it.area = rand_nonpositive();
            else if ($urandom_range(0, 24) == 0)
                it.weight = rand_nonpositive();
        end
        else if (pick < 82)
            it = make_read(FUNC_READ, idx);
        else if (pick < 94)
            it = make_read(FUNC_CLEAR, idx);
        else
            it = make_read(FUNC_READ_ALT, idx);
        return it;
    endfunction

    initial
    begin
        logic [CNT_W-1:0] phase_counts [7];
        phase_counts = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd2, 2'd0, 2'd3};
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, skips, ties, saturation, all function codes
        write_components(2'd3);
        offer_item(make_read(FUNC_READ, 10'd0));
        offer_item(make_acc(10'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        offer_item(make_read(FUNC_READ, 10'd0));
        offer_item(make_read(FUNC_READ_ALT, 10'd0));
        offer_item(make_acc(10'd1023, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer_item(make_acc(10'd1023, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer_item(make_acc(10'd5, Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0));
        offer_item(make_acc(10'd5, Q_ONE, Q_ONE, Q_ONE, '0, Q_MIN));
        offer_item(make_acc(10'd5, Q_ONE, Q_ONE, Q_ONE, '0, 32'sd1));
        offer_item(make_acc(10'd5, Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MAX));
        offer_item(make_acc(10'd5, Q_ONE, Q_ONE, Q_ONE, 32'sd1, 32'sd1));
        offer_item(make_read(FUNC_CLEAR, 10'd1023));
        offer_item(make_read(FUNC_READ, 10'd1023));
        // products landing exactly on half an LSB round away from zero
        offer_item(make_acc(10'd2, 32'sd1, Q_HALF_LSB, Q_ONE, Q_ONE, Q_ONE));
        offer_item(make_acc(10'd2, -32'sd1, Q_HALF_LSB, Q_ONE, Q_ONE, Q_ONE));
        offer_item(make_acc(10'd2, -32'sd1, Q_HALF_LSB, Q_ONE, Q_ONE, Q_ONE));
        offer_item(make_read(FUNC_READ, 10'd2));
        offer_item(make_acc(10'd3, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        offer_item(make_acc(10'd3, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        offer_item(make_acc(10'd3, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        offer_item(make_read(FUNC_CLEAR, 10'd3));
        offer_item(make_read(FUNC_READ, 10'd3));
        s_tvalid <= 1'b0;

        foreach (phase_counts[p])
        begin
            write_components(phase_counts[p]);
            if (p == 6)
                allow_stalls = 1'b0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 60)
                    hold_request = 1'b1;
                if (p == 4 && i == 125)
                begin
                    // stop offering while the block empties out
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                offer_item(make_random_item());
            end
            s_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d accumulates (%0d skipped, %0d clamped), %0d reads, %0d clears",
                 board.n_acc, board.n_skip, board.n_sat, board.n_read, board.n_clear);
        $display("component counts 0..3 exercised, long result hold-off and drained pause");
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_fem_load_vector_accumulator_top: done, clean");
        else
            $display("tb_fem_load_vector_accumulator_top: done, errors");
        $finish;
    end

endmodule
